### hw/rtl/spq_pkg.sv
package spq_pkg;

  // Default store depth
  localparam int DEPTH_DEFAULT = 16;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int PRIO_W  = 8;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_TOP   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Output register occupancy
  typedef enum logic {
    S_IDLE = 1'b0,
    S_HOLD = 1'b1
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;   // execute the accepted command and load the result register
    logic hold;   // result register holds a beat not yet taken
  } spq_ctrl_t;

endpackage

### hw/rtl/spq_req_if.sv
interface spq_req_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::CMD_W-1:0]    command;
  logic [spq_pkg::PRIO_W-1:0]   priority_req;
  logic [spq_pkg::DATA_W-1:0]   payload;

  modport source (output valid, command, priority_req, payload, input ready);
  modport sink   (input valid, command, priority_req, payload, output ready);
endinterface

### hw/rtl/spq_rsp_if.sv
interface spq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [spq_pkg::PRIO_W-1:0]   out_priority;
  logic [spq_pkg::DATA_W-1:0]   out_payload;
  logic                         out_valid;
  logic [spq_pkg::STAT_W-1:0]   status;
  logic [spq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, out_priority, out_payload, out_valid, status, occupancy,
                  input ready);
  modport sink   (input valid, out_priority, out_payload, out_valid, status, occupancy,
                  output ready);
endinterface

### hw/rtl/spq_ctrl.sv
module spq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output spq_pkg::spq_ctrl_t ctrl
);
  import spq_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  // A new beat may enter outside reset when the result register is empty or drains now
  assign req_ready = !rst && ((state == S_IDLE) || rsp_ready);
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_HOLD;
      end
      S_HOLD: begin
        if (rsp_ready && !accept) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl.exec = accept;
    ctrl.hold = 1'b0;
    rsp_valid = 1'b0;
    case (state)
      S_IDLE: begin
        ctrl.hold = 1'b0;
        rsp_valid = 1'b0;
      end
      S_HOLD: begin
        ctrl.hold = 1'b1;
        rsp_valid = 1'b1;
      end
      default: begin
        ctrl.hold = 1'b0;
        rsp_valid = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_holds: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_HOLD)
    else $error("accepted beat did not reach the result register");
  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == S_HOLD && !rsp_ready) |=> state == S_HOLD)
    else $error("result dropped while stalled");
  a_reset_idle: assert property (@(posedge clk)
    rst |=> state == S_IDLE)
    else $error("reset did not empty the result register");
`endif
endmodule

### hw/rtl/spq_dpath.sv
module spq_dpath #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  spq_pkg::spq_ctrl_t          ctrl,
  input  logic [spq_pkg::CMD_W-1:0]   command,
  input  logic [spq_pkg::PRIO_W-1:0]  priority_req,
  input  logic [spq_pkg::DATA_W-1:0]  payload,
  output logic [spq_pkg::PRIO_W-1:0]  out_priority,
  output logic [spq_pkg::DATA_W-1:0]  out_payload,
  output logic                        out_valid,
  output logic [spq_pkg::STAT_W-1:0]  status,
  output logic [spq_pkg::OCC_W-1:0]   occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // Sorted cell row, front at index 0
  logic [PRIO_W-1:0] cell_prio      [DEPTH];
  logic [DATA_W-1:0] cell_data      [DEPTH];
  logic [PRIO_W-1:0] cell_prio_next [DEPTH];
  logic [DATA_W-1:0] cell_data_next [DEPTH];
  logic [DEPTH-1:0]  le;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  cmd_t          op;
  logic          full;
  logic          empty;
  logic          do_push;
  logic          do_pop;

  assign op      = cmd_t'(command);
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = (op == CMD_PUSH) && !full;
  assign do_pop  = (op == CMD_POP) && !empty;

  // Per-cell compare: valid cells that stay ahead of the new entry
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (CW'(i) < count) && (cell_prio[i] <= priority_req);
    end
  end

  // Per-cell next value: keep, take the new entry, or shift
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic ins_here;
    logic [PRIO_W-1:0] up_prio;
    logic [DATA_W-1:0] up_data;

    if (g == 0) begin : g_first
      assign ins_here = 1'b1;
    end else begin : g_rest
      assign ins_here = le[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign up_prio = cell_prio[g];
      assign up_data = cell_data[g];
    end else begin : g_mid
      assign up_prio = cell_prio[g+1];
      assign up_data = cell_data[g+1];
    end

    always_comb begin
      cell_prio_next[g] = cell_prio[g];
      cell_data_next[g] = cell_data[g];
      if (do_push && !le[g]) begin
        if (ins_here) begin
          cell_prio_next[g] = priority_req;
          cell_data_next[g] = payload;
        end else if (g > 0) begin
          cell_prio_next[g] = cell_prio[(g > 0) ? g - 1 : 0];
          cell_data_next[g] = cell_data[(g > 0) ? g - 1 : 0];
        end
      end else if (do_pop) begin
        cell_prio_next[g] = up_prio;
        cell_data_next[g] = up_data;
      end
    end
  end

  // Fill count
  always_comb begin
    count_next = count;
    case (op)
      CMD_PUSH:  if (!full) count_next = count + CW'(1);
      CMD_POP:   if (!empty) count_next = count - CW'(1);
      CMD_TOP:   count_next = count;
      CMD_CLEAR: count_next = '0;
      default:   count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_prio[i] <= cell_prio_next[i];
        cell_data[i] <= cell_data_next[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      out_priority <= '0;
      out_payload  <= '0;
      out_valid    <= 1'b0;
      status       <= ST_OK;
      occupancy    <= OCC_W'(count_next);
      case (op)
        CMD_PUSH: begin
          if (full) status <= ST_FULL;
        end
        CMD_POP, CMD_TOP: begin
          if (empty) begin
            status <= ST_EMPTY;
          end else begin
            out_priority <= cell_prio[0];
            out_payload  <= cell_data[0];
            out_valid    <= 1'b1;
          end
        end
        default: status <= ST_OK;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (ctrl.exec && op == CMD_CLEAR) |=> count == '0)
    else $error("clear left entries behind");
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (ctrl.exec && op == CMD_PUSH && full) |=> (count == $past(count)))
    else $error("push on a full store changed the count");
  a_no_exec_hold: assert property (@(posedge clk) disable iff (rst)
    (!ctrl.exec && ctrl.hold) |=> (count == $past(count)))
    else $error("store changed without a command");
`endif
endmodule

### hw/rtl/sorted_priority_queue_unit.sv
// Sorted priority queue, DEPTH cells of priority and payload, lowest number in front.
// Each result beat is registered and presented in the cycle after its command beat is accepted.
// Throughput: one command per cycle while results are taken; every cell compares
// against the new priority at once and, on a push, the cells behind the insertion point shift in that same cycle.
// Reset: rst (synchronous) empties the queue and the result register; cells are not cleared.
module sorted_priority_queue_unit #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  spq_ctrl_t ctrl;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctrl      (ctrl)
  );

  spq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .command      (req.command),
    .priority_req (req.priority_req),
    .payload      (req.payload),
    .out_priority (rsp.out_priority),
    .out_payload  (rsp.out_payload),
    .out_valid    (rsp.out_valid),
    .status       (rsp.status),
    .occupancy    (rsp.occupancy)
  );

endmodule
